// File: rtl/emb_pkg.sv
// Package: shared types and constants for the entropy mixer byte FIFO.
`timescale 1ns / 1ps

package emb_pkg;

    localparam int EMB_FIFO_BYTES  = 64;
    localparam int EMB_ROUNDS      = 8;
    localparam int EMB_WORD_BYTES  = 8;
    localparam int EMB_MAX_READ    = 8;
    localparam int EMB_FILL_W      = 7;
    localparam int EMB_LEN_W       = 4;

    localparam logic [63:0] EMB_FNV_BASIS   = 64'hcbf2_9ce4_8422_2325;
    // FNV prime 0x100000001B3 is 2^40 + 0x1B3
    localparam logic [8:0]  EMB_PRIME_LO    = 9'h1B3;
    localparam int          EMB_PRIME_SHIFT = 40;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_FLUSH  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [63:0]  entropy_word;
        logic [31:0]  timestamp_ms;
        logic [3:0]   read_length;
    } t_in_word;

    typedef struct packed {
        logic [7:0]   read_byte;
        logic         has_data;
        logic         last;
        logic [6:0]   fill_level;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_MUL,
        ST_MIX_ADD,
        ST_PUSH,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RD_EMPTY
    } t_state;

    typedef struct packed {
        logic mix_load;
        logic mix_mul;
        logic mix_add;
        logic push;
        logic flush;
        logic rd_start;
        logic rd_issue;
        logic rd_load;
        logic rd_empty;
    } t_cmd;

    typedef struct packed {
        logic room;
        logic rd_zero;
        logic rem_zero;
        logic push_last;
        logic round_wrap;
        logic out_free;
    } t_status;

endpackage

// File: rtl/emb_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module emb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/emb_ctrl.sv
// Controller: sequences mixing, word pushes and byte reads.
`timescale 1ns / 1ps

module emb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  emb_pkg::t_kind   i_kind,
    input  emb_pkg::t_status i_status,
    output logic             o_in_ready,
    output emb_pkg::t_cmd    o_cmd
);

    import emb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_SAMPLE: begin
                            if (i_status.room) begin
                                o_cmd.mix_load = 1'b1;
                                n_state        = ST_MIX_MUL;
                            end
                        end
                        KIND_READ: begin
                            o_cmd.rd_start = 1'b1;
                            n_state = i_status.rd_zero ? ST_RD_EMPTY : ST_RD_ADDR;
                        end
                        KIND_FLUSH: begin
                            o_cmd.flush = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MIX_MUL: begin
                o_cmd.mix_mul = 1'b1;
                n_state       = ST_MIX_ADD;
            end
            ST_MIX_ADD: begin
                o_cmd.mix_add = 1'b1;
                n_state       = i_status.round_wrap ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_status.push_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                if (i_status.out_free) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = ST_RD_DATA;
                end
            end
            ST_RD_DATA: begin
                o_cmd.rd_load = 1'b1;
                n_state       = i_status.rem_zero ? ST_IDLE : ST_RD_ADDR;
            end
            ST_RD_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.rd_empty = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/emb_dpath.sv
// Datapath: FNV mixer, byte FIFO pointers and store, output register.
`timescale 1ns / 1ps

module emb_dpath #(
    parameter int FIFO_BYTES      = emb_pkg::EMB_FIFO_BYTES,
    parameter int ROUNDS_PER_WORD = emb_pkg::EMB_ROUNDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  emb_pkg::t_in_word  i_in,
    input  emb_pkg::t_cmd      i_cmd,
    output emb_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output emb_pkg::t_out_word o_out
);

    import emb_pkg::*;

    localparam int PTR_W = $clog2(FIFO_BYTES);
    localparam int CNT_W = $clog2(FIFO_BYTES + 1);
    localparam int RND_W = (ROUNDS_PER_WORD > 1) ? $clog2(ROUNDS_PER_WORD) : 1;
    localparam int IDX_W = $clog2(EMB_WORD_BYTES);

    logic [63:0]          r_acc;
    logic [63:0]          r_mix;
    logic [63:0]          r_prod;
    logic [63:0]          r_shift;
    logic [RND_W-1:0]     r_round;
    logic [IDX_W-1:0]     r_idx;
    logic [PTR_W-1:0]     r_wptr;
    logic [PTR_W-1:0]     r_rptr;
    logic [CNT_W-1:0]     r_count;
    logic [EMB_LEN_W-1:0] r_remain;
    logic                 r_out_valid;
    t_out_word            r_out;

    logic [EMB_LEN_W-1:0] want;
    logic [EMB_LEN_W-1:0] n_remain;
    logic [7:0]           ram_rdata;
    logic [7:0]           push_byte;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(FIFO_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    // clamp the requested length, then limit by what the FIFO holds
    always_comb begin
        want = (i_in.read_length > EMB_LEN_W'(EMB_MAX_READ)) ?
               EMB_LEN_W'(EMB_MAX_READ) : i_in.read_length;
        n_remain = (r_count >= CNT_W'(want)) ? want : EMB_LEN_W'(r_count);
    end

    assign push_byte = r_acc[r_idx*8 +: 8];

    assign o_status.room       = (r_count <= CNT_W'(FIFO_BYTES - EMB_WORD_BYTES));
    assign o_status.rd_zero    = (n_remain == '0);
    assign o_status.rem_zero   = (r_remain == '0);
    assign o_status.push_last  = (r_idx == IDX_W'(EMB_WORD_BYTES - 1));
    assign o_status.round_wrap = (r_round == RND_W'(ROUNDS_PER_WORD - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= EMB_FNV_BASIS;
            r_round     <= '0;
            r_idx       <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mix_add) begin
                r_acc   <= r_prod + r_shift;
                r_round <= o_status.round_wrap ? '0 : r_round + 1'b1;
            end
            if (i_cmd.push) begin
                r_idx   <= r_idx + 1'b1;
                r_wptr  <= ptr_next(r_wptr);
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.rd_start) begin
                r_remain <= n_remain;
            end
            if (i_cmd.rd_issue) begin
                r_rptr   <= ptr_next(r_rptr);
                r_count  <= r_count - 1'b1;
                r_remain <= r_remain - 1'b1;
            end
            if (i_cmd.flush) begin
                r_wptr  <= '0;
                r_rptr  <= '0;
                r_count <= '0;
            end
            if (i_cmd.rd_load || i_cmd.rd_empty) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_load) begin
            r_mix <= ((r_round == '0) ? EMB_FNV_BASIS : r_acc) ^ i_in.entropy_word ^
                     {32'd0, i_in.timestamp_ms};
        end
        if (i_cmd.mix_mul) begin
            r_prod  <= r_mix * 64'(EMB_PRIME_LO);
            r_shift <= r_mix << EMB_PRIME_SHIFT;
        end
        if (i_cmd.rd_load) begin
            r_out.read_byte  <= ram_rdata;
            r_out.has_data   <= 1'b1;
            r_out.last       <= (r_remain == '0);
            r_out.fill_level <= EMB_FILL_W'(r_count);
        end else if (i_cmd.rd_empty) begin
            r_out.read_byte  <= '0;
            r_out.has_data   <= 1'b0;
            r_out.last       <= 1'b1;
            r_out.fill_level <= EMB_FILL_W'(r_count);
        end
    end

    emb_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wptr),
        .i_wdata (push_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/entropy_mixer_byte_fifo_top.sv
// Top level: FNV-1a entropy conditioner feeding a byte FIFO.
`timescale 1ns / 1ps

// Words on the input channel are samples, read requests or flushes; one word is
// handled at a time. A sample that is mixed passes three steps (load and XOR,
// multiply by the low part of the prime, add the shifted high part); every
// ROUNDS_PER_WORD-th mixed sample then writes the eight accumulator bytes into the
// byte store, least significant byte first, one byte per cycle. A sample that
// arrives with fewer than eight free bytes is dropped in its acceptance cycle.
// After acceptance a read pops up to eight bytes; each byte is addressed once the
// output register is free, then loaded from the registered read port of the byte
// store; an empty read answers with a single word once the output register is
// free. Flush empties the FIFO and keeps the mixer state. A finished output word
// waits in its own register, so the next input word is taken while it is still
// pending.
module entropy_mixer_byte_fifo_top #(
    parameter int FIFO_BYTES      = emb_pkg::EMB_FIFO_BYTES,
    parameter int ROUNDS_PER_WORD = emb_pkg::EMB_ROUNDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  emb_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output emb_pkg::t_out_word o_out
);

    import emb_pkg::*;

    t_cmd    cmd;
    t_status status;

    emb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in.kind),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    emb_dpath #(
        .FIFO_BYTES      (FIFO_BYTES),
        .ROUNDS_PER_WORD (ROUNDS_PER_WORD)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: tb/sv/entropy_mixer_byte_fifo_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the entropy mixer byte FIFO: directed table, random bursts, word-by-word check.
module entropy_mixer_byte_fifo_top_tb;
    import emb_pkg::*;

    localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01B3;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          PHASE_WORDS = 130;

    localparam t_out_word   EMPTY_READ  = '{8'h00, 1'b0, 1'b1, 7'd0};
    localparam t_out_word   HELD_EIGHT  = '{8'h00, 1'b0, 1'b1, 7'd8};

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    t_in_word    in_word;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready;
    t_out_word   out_word;

    logic [63:0] acc;
    int unsigned round_cnt;
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned fill;
    logic [7:0]  fifo_mem [EMB_FIFO_BYTES];
    t_out_word   bytes_due [$];
    t_row        directed_rows [$];

    int          err_count   = 0;
    int unsigned cycle_count = 0;
    int          words_sent  = 0;
    int          send_idle_pct;
    int          recv_stall_pct;

    entropy_mixer_byte_fifo_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void advance_conditioner(input t_in_word w, input bit record);
        int unsigned want;
        int unsigned n;
        t_out_word   r;
        case (w.kind)
            KIND_SAMPLE: begin
                if (EMB_FIFO_BYTES - fill >= EMB_WORD_BYTES) begin
                    if (round_cnt == 0) acc = EMB_FNV_BASIS;
                    acc = (acc ^ w.entropy_word ^ {32'd0, w.timestamp_ms}) * FNV_PRIME;
                    round_cnt++;
                    if (round_cnt == EMB_ROUNDS) begin
                        round_cnt = 0;
                        for (int k = 0; k < EMB_WORD_BYTES; k++) begin
                            fifo_mem[wr_ptr] = acc[8*k +: 8];
                            wr_ptr = (wr_ptr + 1) % EMB_FIFO_BYTES;
                            fill++;
                        end
                    end
                end
            end
            KIND_READ: begin
                want = (w.read_length > EMB_MAX_READ) ? EMB_MAX_READ : w.read_length;
                n    = (want < fill) ? want : fill;
                if (n == 0) begin
                    r = '{8'h00, 1'b0, 1'b1, fill[6:0]};
                    if (record) bytes_due.push_back(r);
                end
                for (int k = 0; k < n; k++) begin
                    r.read_byte = fifo_mem[rd_ptr];
                    rd_ptr      = (rd_ptr + 1) % EMB_FIFO_BYTES;
                    fill--;
                    r.has_data   = 1'b1;
                    r.last       = (k + 1 == n);
                    r.fill_level = fill[6:0];
                    if (record) bytes_due.push_back(r);
                end
            end
            KIND_FLUSH: begin
                rd_ptr = 0;
                wr_ptr = 0;
                fill   = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_word word_of(input t_kind kind, input logic [63:0] sample,
                                         input logic [31:0] stamp, input logic [3:0] len);
        t_in_word w;
        w.kind         = kind;
        w.entropy_word = sample;
        w.timestamp_ms = stamp;
        w.read_length  = len;
        return w;
    endfunction

    function automatic t_row row(input t_in_word w, input bit typed, input t_out_word want);
        t_row r;
        r.w     = w;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [3:0] pick_length();
        if ($urandom_range(9) == 0) return 4'($urandom);
        return 4'($urandom_range(1, 8));
    endfunction

    function automatic t_in_word make_word(input t_kind kind, input logic [3:0] len);
        t_in_word w;
        w = word_of(kind, {$urandom, $urandom}, $urandom, len);
        if ($urandom_range(7) == 0) w.entropy_word = {64{1'($urandom_range(1))}};
        if ($urandom_range(7) == 0) w.timestamp_ms = {32{1'($urandom_range(1))}};
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic issue(input t_in_word w);
        send_word(w);
        advance_conditioner(w, 1'b1);
        if (w.kind != KIND_NONE) words_sent++;
    endtask

    task automatic hold_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (bytes_due.size() != 0);
    endtask

    task automatic random_burst(input int count);
        int target;
        int pick;
        target = words_sent + count;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                repeat (8 * $urandom_range(1, 8)) issue(make_word(KIND_SAMPLE, pick_length()));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 10)) issue(make_word(KIND_READ, pick_length()));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 7)) issue(make_word(KIND_SAMPLE, pick_length()));
            end else if (pick < 91) begin
                issue(make_word(KIND_FLUSH, pick_length()));
            end else if (pick < 96) begin
                issue(make_word(KIND_NONE, pick_length()));
            end else begin
                hold_for_results();
            end
        end
    endtask

    always @(posedge clk) begin : check_results
        t_out_word exp;
        if (rst_n && out_valid && out_ready) begin
            if (bytes_due.size() == 0) begin
                err_count++;
                $error("unexpected word %p", out_word);
            end else begin
                exp = bytes_due.pop_front();
                if (out_word.read_byte !== exp.read_byte) begin
                    err_count++;
                    $error("read_byte expected %0h got %0h", exp.read_byte, out_word.read_byte);
                end
                if (out_word.has_data !== exp.has_data) begin
                    err_count++;
                    $error("has_data expected %0b got %0b", exp.has_data, out_word.has_data);
                end
                if (out_word.last !== exp.last) begin
                    err_count++;
                    $error("last expected %0b got %0b", exp.last, out_word.last);
                end
                if (out_word.fill_level !== exp.fill_level) begin
                    err_count++;
                    $error("fill_level expected %0d got %0d", exp.fill_level,
                           out_word.fill_level);
                end
            end
        end
        out_ready <= rst_n ? ($urandom_range(99) >= recv_stall_pct) : 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        out_ready <= 1'b0;
        acc       = EMB_FNV_BASIS;
        round_cnt = 0;
        rd_ptr    = 0;
        wr_ptr    = 0;
        fill      = 0;
        send_idle_pct  = 6;
        recv_stall_pct = 81;

        directed_rows.push_back(row(word_of(KIND_READ, '0, '0, 4'd1), 1'b1, EMPTY_READ));
        directed_rows.push_back(row(word_of(KIND_READ, '1, '1, 4'd0), 1'b1, EMPTY_READ));
        directed_rows.push_back(row(word_of(KIND_READ, '0, '0, 4'd15), 1'b1, EMPTY_READ));
        directed_rows.push_back(row(word_of(KIND_NONE, '1, '1, 4'd15), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_FLUSH, '0, '0, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, '0, '0, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, '1, '1, 4'd15), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, '0, '1, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, '1, '0, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, 64'haaaa_aaaa_aaaa_aaaa,
                                            32'h5555_5555, 4'd5), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, 64'h5555_5555_5555_5555,
                                            32'haaaa_aaaa, 4'd10), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, 64'h0123_4567_89ab_cdef,
                                            32'hdead_beef, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, 64'h8000_0000_0000_0001,
                                            32'h8000_0001, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_READ, '0, '0, 4'd0), 1'b1, HELD_EIGHT));
        directed_rows.push_back(row(word_of(KIND_READ, '0, '0, 4'd3), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_READ, '0, '0, 4'd15), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_READ, '0, '0, 4'd2), 1'b1, EMPTY_READ));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, 64'hffff_0000_ffff_0000,
                                            32'h0000_ffff, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, 64'h0000_ffff_0000_ffff,
                                            32'hffff_0000, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, '1, '0, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_SAMPLE, '0, '1, 4'd0), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_FLUSH, '1, '1, 4'd15), 1'b0, '0));
        directed_rows.push_back(row(word_of(KIND_READ, '0, '0, 4'd8), 1'b1, EMPTY_READ));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].w);
            advance_conditioner(directed_rows[i].w, !directed_rows[i].typed);
            if (directed_rows[i].typed) bytes_due.push_back(directed_rows[i].want);
        end

        random_burst(PHASE_WORDS);
        hold_for_results();
        send_idle_pct  = 81;
        recv_stall_pct = 6;
        random_burst(PHASE_WORDS);
        hold_for_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_burst(PHASE_WORDS);

        in_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
